// ----- rtl/psfc_pkg.sv -----
// Package for the particle step with frustum cull block.
// Payload structs, fixed constants and small helpers; no dependencies.
package psfc_pkg;

  localparam int PLANE_COUNT = 6;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 64;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_PLANE_0 = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PLANE_5 = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_CAMERA  = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_GRAVITY = 3'd7;

  localparam logic [15:0] GRAVITY_RESET = 16'd2509;

  typedef struct packed {
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic signed [15:0] pos_z;
    logic signed [15:0] dir_x;
    logic signed [15:0] dir_y;
    logic signed [15:0] dir_z;
    logic [15:0]        speed;
    logic [15:0]        age;
    logic [15:0]        life_time;
    logic               active;
    logic [15:0]        delta_time;
    logic               end_of_batch;
  } in_item_t;

  typedef struct packed {
    logic signed [15:0] new_pos_x;
    logic signed [15:0] new_pos_y;
    logic signed [15:0] new_pos_z;
    logic signed [15:0] out_dir_x;
    logic signed [15:0] new_dir_y;
    logic signed [15:0] out_dir_z;
    logic [15:0]        new_age;
    logic               still_active;
    logic               visible;
    logic [7:0]         alpha;
    logic               batch_end;
  } out_item_t;

  function automatic logic signed [15:0] sat16(input logic signed [25:0] v);
    if (v > 26'sd32767) return 16'sh7fff;
    if (v < -26'sd32768) return -16'sh8000;
    return v[15:0];
  endfunction

endpackage

// ----- rtl/psfc_div.sv -----
// Pipelined restoring divider for the alpha fade, 24-bit dividend / 16-bit divisor.
// One quotient bit per stage, shares the pipeline's advance; no package dependency.
module psfc_div #(
  parameter int NUM_W = 24,
  parameter int DEN_W = 16,
  parameter int Q_W   = 8
) (
  input  logic                  clk,
  input  logic                  adv,
  input  logic [NUM_W-1:0]      num,
  input  logic [DEN_W-1:0]      den,
  output logic [Q_W-1:0]        quo
);
  // quotient fits in Q_W bits (num < den * 2^Q_W), so the top DEN_W bits of num
  // already sit below den and each stage brings down one of the low bits
  logic [DEN_W-1:0] rem_r [Q_W];
  logic [NUM_W-1:0] num_r [Q_W];
  logic [DEN_W-1:0] den_r [Q_W];
  logic [Q_W-1:0]   q_r   [Q_W];

  for (genvar s = 0; s < Q_W; s++) begin : g_step
    localparam int BIT = NUM_W - DEN_W - 1 - s;
    logic [DEN_W-1:0] rem_in;
    logic [NUM_W-1:0] num_in;
    logic [DEN_W-1:0] den_in;
    logic [Q_W-1:0]   q_in;
    logic [DEN_W:0]   sh;
    logic [DEN_W+1:0] trial;
    if (s == 0) begin : g_first
      assign rem_in = num[NUM_W-1 -: DEN_W];
      assign num_in = num;
      assign den_in = den;
      assign q_in   = '0;
    end else begin : g_next
      assign rem_in = rem_r[s-1];
      assign num_in = num_r[s-1];
      assign den_in = den_r[s-1];
      assign q_in   = q_r[s-1];
    end
    always_comb begin
      sh    = {rem_in, num_in[BIT]};
      trial = {1'b0, sh} - {2'b00, den_in};
    end
    always_ff @(posedge clk) begin
      if (adv) begin
        rem_r[s] <= trial[DEN_W+1] ? sh[DEN_W-1:0] : trial[DEN_W-1:0];
        num_r[s] <= num_in;
        den_r[s] <= den_in;
        q_r[s]   <= {q_in[Q_W-2:0], ~trial[DEN_W+1]};
      end
    end
  end

  assign quo = q_r[Q_W-1];
endmodule

// ----- rtl/particle_step_with_frustum_cull.sv -----
// Particle step with frustum cull: Euler move, gravity, ageing, fade and
// visibility test, one particle per cycle unless a stalled output holds the pipe. Three
// arithmetic stages feed an eight-stage alpha divider, then an output register;
// the distance and frustum tests take two stages beside the divider.
// The whole pipeline advances together; out_stall on a valid output holds every stage.
module particle_step_with_frustum_cull #(
  parameter int MAX_ALPHA     = 255,
  parameter int VIEW_DISTANCE = 100
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  psfc_pkg::in_item_t                  in_data,
  output logic                                out_valid,
  input  logic                                out_stall,
  output psfc_pkg::out_item_t                 out_data,
  input  logic                                cfg_we,
  input  logic [psfc_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [psfc_pkg::CFG_DATA_W-1:0]     cfg_data
);
  localparam int DIV_STAGES = 8;
  localparam int NSTG = 3 + DIV_STAGES;
  localparam logic [35:0] LIM = 36'(VIEW_DISTANCE * 256) * 36'(VIEW_DISTANCE * 256);

  logic [63:0] plane_r [psfc_pkg::PLANE_COUNT];
  logic [47:0] cam_r;
  logic [15:0] grav_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < psfc_pkg::PLANE_COUNT; i++) plane_r[i] <= '0;
      cam_r  <= '0;
      grav_r <= psfc_pkg::GRAVITY_RESET;
    end else if (cfg_we) begin
      if (cfg_index == psfc_pkg::REG_CAMERA) cam_r <= cfg_data[47:0];
      else if (cfg_index == psfc_pkg::REG_GRAVITY) grav_r <= cfg_data[15:0];
      else if (cfg_index <= psfc_pkg::REG_PLANE_5)
        plane_r[cfg_index] <= cfg_data;
    end
  end

  // single global advance: whole pipe moves unless the output is held
  logic adv;
  logic [NSTG:0] vld_r;
  assign adv      = !(out_valid && out_stall);
  assign in_stall = !adv;
  assign out_valid = vld_r[NSTG];

  always_ff @(posedge clk) begin
    if (!rst_n) vld_r <= '0;
    else if (adv) vld_r <= {vld_r[NSTG-1:0], in_valid};
  end

  // ---- stage 1: dir*speed, gravity*dt, age
  psfc_pkg::in_item_t s1_r;
  logic signed [32:0] s1_ds_r [3];
  logic [31:0] s1_gd_r;
  logic [16:0] s1_age_r;
  always_ff @(posedge clk) begin
    if (adv) begin
      s1_r <= in_data;
      s1_ds_r[0] <= in_data.dir_x * $signed({1'b0, in_data.speed});
      s1_ds_r[1] <= in_data.dir_y * $signed({1'b0, in_data.speed});
      s1_ds_r[2] <= in_data.dir_z * $signed({1'b0, in_data.speed});
      s1_gd_r  <= grav_r * in_data.delta_time;
      s1_age_r <= {1'b0, in_data.age} + {1'b0, in_data.delta_time};
    end
  end

  // ---- stage 2: *dt, dir_y, age saturation
  psfc_pkg::in_item_t s2_r;
  logic signed [49:0] s2_d_r [3];
  logic signed [15:0] s2_ndy_r;
  logic [15:0] s2_age_r;
  always_ff @(posedge clk) begin
    if (adv) begin
      s2_r <= s1_r;
      for (int k = 0; k < 3; k++)
        s2_d_r[k] <= s1_ds_r[k] * $signed({1'b0, s1_r.delta_time});
      s2_ndy_r <= psfc_pkg::sat16(26'(s1_r.dir_y) - 26'($signed({1'b0, s1_gd_r[31:8]})));
      s2_age_r <= s1_age_r[16] ? 16'hffff : s1_age_r[15:0];
    end
  end

  // ---- stage 3: new positions, alive, alpha numerator
  psfc_pkg::in_item_t s3_r;
  logic signed [15:0] s3_np_r [3];
  logic signed [15:0] s3_ndy_r;
  logic [15:0] s3_age_r;
  logic s3_alive_r;
  logic [23:0] s3_anum_r;
  always_ff @(posedge clk) begin
    logic signed [33:0] sh;
    logic signed [34:0] sum;
    if (adv) begin
      s3_r <= s2_r;
      for (int k = 0; k < 3; k++) begin
        sh  = s2_d_r[k][49:16];
        sum = 35'(sh) + (k == 0 ? 35'(s2_r.pos_x) : k == 1 ? 35'(s2_r.pos_y) : 35'(s2_r.pos_z));
        if (!s2_r.active)
          s3_np_r[k] <= k == 0 ? s2_r.pos_x : k == 1 ? s2_r.pos_y : s2_r.pos_z;
        else if (sum > 35'sd32767) s3_np_r[k] <= 16'sh7fff;
        else if (sum < -35'sd32768) s3_np_r[k] <= -16'sh8000;
        else s3_np_r[k] <= sum[15:0];
      end
      s3_ndy_r <= s2_r.active ? s2_ndy_r : s2_r.dir_y;
      s3_age_r <= s2_r.active ? s2_age_r : s2_r.age;
      s3_alive_r <= s2_r.active && (s2_age_r < s2_r.life_time);
      s3_anum_r <= (s2_r.life_time - s2_age_r) * 8'(MAX_ALPHA);
    end
  end

  // ---- stage 4: camera deltas and plane products
  logic signed [16:0] s4_df_r [3];
  logic signed [33:0] s4_pl_r [psfc_pkg::PLANE_COUNT];
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < 3; k++)
        s4_df_r[k] <= 17'(s3_np_r[k]) - 17'($signed(cam_r[16*k +: 16]));
      for (int p = 0; p < psfc_pkg::PLANE_COUNT; p++)
        s4_pl_r[p] <= $signed(plane_r[p][15:0]) * s3_np_r[0]
                    + $signed(plane_r[p][31:16]) * s3_np_r[1]
                    + $signed(plane_r[p][47:32]) * s3_np_r[2]
                    + $signed({plane_r[p][63:48], 8'h00});
    end
  end

  // ---- stage 5: distance square and visibility
  logic s5_vis_r;
  always_ff @(posedge clk) begin
    logic [35:0] dsq;
    logic signed [33:0] sq;
    logic in_all;
    if (adv) begin
      dsq = '0;
      for (int k = 0; k < 3; k++) begin
        sq  = s4_df_r[k] * s4_df_r[k];
        dsq = dsq + 36'(sq);
      end
      in_all = 1'b1;
      for (int p = 0; p < psfc_pkg::PLANE_COUNT; p++)
        if (s4_pl_r[p][33]) in_all = 1'b0;
      s5_vis_r <= (dsq <= LIM) && in_all;
    end
  end

  // delay lines for the non-alpha fields across the divider
  psfc_pkg::out_item_t dl_r [NSTG-3];
  logic vis_d_r [NSTG-5];
  always_ff @(posedge clk) begin
    if (adv) begin
      dl_r[0] <= '{s3_np_r[0], s3_np_r[1], s3_np_r[2], s3_r.dir_x, s3_ndy_r, s3_r.dir_z,
                  s3_age_r, s3_alive_r, 1'b0, 8'd0, s3_r.end_of_batch};
      for (int i = 1; i < NSTG-3; i++) dl_r[i] <= dl_r[i-1];
      vis_d_r[0] <= s5_vis_r;
      for (int i = 1; i < NSTG-5; i++) vis_d_r[i] <= vis_d_r[i-1];
    end
  end

  logic [7:0] quo;
  psfc_div #(.NUM_W(24), .DEN_W(16), .Q_W(DIV_STAGES)) u_div (
    .clk(clk), .adv(adv),
    .num(s3_anum_r), .den(s3_r.life_time), .quo(quo)
  );

  always_ff @(posedge clk) begin
    psfc_pkg::out_item_t res;
    if (adv) begin
      res         = dl_r[NSTG-4];
      res.visible = dl_r[NSTG-4].still_active && vis_d_r[NSTG-6];
      res.alpha   = dl_r[NSTG-4].still_active ? quo : 8'd0;
      out_data   <= res;
    end
  end

  ap_no_vis_dead: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.visible |-> out_data.still_active)
    else $error("visible without alive");
  ap_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("output changed under stall");
  ap_alpha: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.still_active |-> out_data.alpha == 8'd0)
    else $error("alpha on dead particle");
endmodule
